[design/wshc_pkg.sv]
// Shared types, constants and helpers for the window size hint constraint block.
// Used by wshc_div, wshc_step and window_size_hint_constrain; depends on nothing.

package wshc_pkg;

    // Coordinate range that results saturate to.
    localparam int COORD_BITS = 16;
    localparam longint SAT_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;

    // Pipelined divider geometry: 32-bit dividend, 16-bit divisor.
    localparam int DIV_W      = 32;
    localparam int DEN_W      = 16;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;

    // One aspect step: product stage, two divider passes, product stage, update stage.
    localparam int STEP_LAT   = 2 * DIV_STAGES + 3;
    localparam int NUM_STEPS  = 4;
    // Edges from the accepting edge to the edge that takes the result.
    localparam int RESULT_LAT = 5 + DIV_STAGES + NUM_STEPS * STEP_LAT;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SIZE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SIZE      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_SIZE     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SIZE_STEP     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ASP_MIN       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ASP_MAX       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_EXTRA   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_ASPECT_ENABLE = 3'd7;

    // Register reset values.
    localparam logic [31:0] MIN_SIZE_RST    = 32'h0000_0000;
    localparam logic [31:0] MAX_SIZE_RST    = 32'hFFFF_FFFF;
    localparam logic [31:0] BASE_SIZE_RST   = 32'h0000_0000;
    localparam logic [31:0] SIZE_STEP_RST   = 32'h0001_0001;
    localparam logic [31:0] ASP_MIN_RST     = 32'h0001_0001;
    localparam logic [31:0] ASP_MAX_RST     = 32'h0001_0001;
    localparam logic [31:0] FRAME_EXTRA_RST = 32'h0000_0000;

    // Aspect correction steps, in the order they are applied.
    localparam logic [1:0] MODE_MIN_FIT  = 2'd0;
    localparam logic [1:0] MODE_MIN_TRIM = 2'd1;
    localparam logic [1:0] MODE_MAX_FIT  = 2'd2;
    localparam logic [1:0] MODE_MAX_TRIM = 2'd3;
    localparam logic [1:0] STEP_ORDER [NUM_STEPS] =
        '{MODE_MIN_FIT, MODE_MIN_TRIM, MODE_MAX_FIT, MODE_MAX_TRIM};

    typedef struct packed {
        logic [31:0] min_size;
        logic [31:0] max_size;
        logic [31:0] base_size;
        logic [31:0] size_step;
        logic [31:0] asp_min;
        logic [31:0] asp_max;
        logic [31:0] frame_extra;
        logic        aspect_enable;
    } cfg_t;

    // Per-transaction state that travels down the pipeline.
    typedef struct packed {
        logic [15:0] w;     // client width
        logic [15:0] h;     // client height
        logic [15:0] rh;    // requested height, kept for shaded windows
        logic        xz;    // no horizontal resize
        logic        yz;    // no vertical resize
        logic        sh;    // shaded
        logic        cond;  // aspect test of the current step holds
        logic        nx;    // width below base before snapping
        logic        ny;    // height below base before snapping
    } item_t;

    // A zero increment or aspect term is used as one.
    function automatic logic [15:0] nz16(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // Saturate a non-negative frame size to the coordinate range.
    function automatic logic [15:0] sat_out(input logic [17:0] v);
        if ({46'd0, v} > 64'(SAT_MAX))
            return 16'(SAT_MAX);
        else
            return v[15:0];
    endfunction

endpackage

[design/wshc_div.sv]
// Pipelined unsigned divider, 32-bit dividend by 16-bit divisor, with a
// transaction record carried alongside. Depends on wshc_pkg.

module wshc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [31:0]         num,
    input  logic [15:0]         den,
    input  wshc_pkg::item_t     in_item,
    output logic                out_valid,
    output logic [31:0]         quo,
    output wshc_pkg::item_t     out_item
);

    logic                 v_reg    [wshc_pkg::DIV_STAGES];
    logic [15:0]          rem_reg  [wshc_pkg::DIV_STAGES];
    logic [31:0]          num_reg  [wshc_pkg::DIV_STAGES];
    logic [31:0]          quo_reg  [wshc_pkg::DIV_STAGES];
    logic [15:0]          den_reg  [wshc_pkg::DIV_STAGES];
    wshc_pkg::item_t      item_reg [wshc_pkg::DIV_STAGES];

    logic [15:0]          rem_next [wshc_pkg::DIV_STAGES];
    logic [31:0]          num_next [wshc_pkg::DIV_STAGES];
    logic [31:0]          quo_next [wshc_pkg::DIV_STAGES];
    logic [15:0]          src_rem  [wshc_pkg::DIV_STAGES];
    logic [31:0]          src_num  [wshc_pkg::DIV_STAGES];
    logic [31:0]          src_quo  [wshc_pkg::DIV_STAGES];
    logic [15:0]          src_den  [wshc_pkg::DIV_STAGES];

    // Each stage takes its operands from the previous stage, the first from the ports.
    always_comb
    begin
        src_rem[0] = 16'd0;
        src_num[0] = num;
        src_quo[0] = 32'd0;
        src_den[0] = den;
        for (int s = 1; s < wshc_pkg::DIV_STAGES; s++)
        begin
            src_rem[s] = rem_reg[s-1];
            src_num[s] = num_reg[s-1];
            src_quo[s] = quo_reg[s-1];
            src_den[s] = den_reg[s-1];
        end
    end

    // Restoring division, a few quotient bits per stage.
    always_comb
    begin
        logic [15:0] r;
        logic [31:0] n;
        logic [31:0] q;
        logic [16:0] t;
        for (int s = 0; s < wshc_pkg::DIV_STAGES; s++)
        begin
            r = src_rem[s];
            n = src_num[s];
            q = src_quo[s];
            for (int k = 0; k < wshc_pkg::DIV_STEP; k++)
            begin
                t = {r, n[31]};
                n = {n[30:0], 1'b0};
                if (t >= {1'b0, src_den[s]})
                begin
                    t = t - {1'b0, src_den[s]};
                    q = {q[30:0], 1'b1};
                end
                else
                begin
                    q = {q[30:0], 1'b0};
                end
                r = t[15:0];
            end
            rem_next[s] = r;
            num_next[s] = n;
            quo_next[s] = q;
        end
    end

    // Valid bits are the only state that reset clears.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < wshc_pkg::DIV_STAGES; s++)
                v_reg[s] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < wshc_pkg::DIV_STAGES; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        item_reg[0] <= in_item;
        for (int s = 1; s < wshc_pkg::DIV_STAGES; s++)
            item_reg[s] <= item_reg[s-1];
        for (int s = 0; s < wshc_pkg::DIV_STAGES; s++)
        begin
            rem_reg[s] <= rem_next[s];
            num_reg[s] <= num_next[s];
            quo_reg[s] <= quo_next[s];
            den_reg[s] <= src_den[s];
        end
    end

    assign out_valid = v_reg[wshc_pkg::DIV_STAGES-1];
    assign quo       = quo_reg[wshc_pkg::DIV_STAGES-1];
    assign out_item  = item_reg[wshc_pkg::DIV_STAGES-1];

endmodule

[design/wshc_step.sv]
// One aspect ratio correction step of the size constraint pipeline.
// Depends on wshc_pkg and wshc_div.

module wshc_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          mode,
    input  wshc_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  wshc_pkg::item_t     in_item,
    output logic                out_valid,
    output wshc_pkg::item_t     out_item
);

    logic            is_min;
    logic [15:0]     ax;
    logic [15:0]     ay;
    logic [15:0]     xi;
    logic [15:0]     yi;

    logic            p_v_reg;
    wshc_pkg::item_t p_item_reg;
    logic [31:0]     ph_reg;
    logic [31:0]     pw_reg;
    wshc_pkg::item_t p_item;

    logic            d1_v;
    logic [31:0]     d1_qx;
    logic [31:0]     d1_qy;
    wshc_pkg::item_t d1_item;
    logic [31:0]     w32;
    logic [31:0]     h32;
    logic [31:0]     tx;
    logic [31:0]     ty;

    logic            d2_v;
    logic [31:0]     d2_qx;
    logic [31:0]     d2_qy;
    wshc_pkg::item_t d2_item;
    logic [47:0]     dx_full;
    logic [47:0]     dy_full;

    logic            m_v_reg;
    wshc_pkg::item_t m_item_reg;
    logic [31:0]     dx_reg;
    logic [31:0]     dy_reg;

    logic [32:0]     w33;
    logic [32:0]     h33;
    logic            grow_w_ok;
    logic            grow_h_ok;
    logic            trim_w_ok;
    logic            trim_h_ok;
    logic            active;
    wshc_pkg::item_t res_next;

    logic            out_v_reg;
    wshc_pkg::item_t out_item_reg;

    // Aspect terms and increments for this step.
    assign is_min = (mode == wshc_pkg::MODE_MIN_FIT) || (mode == wshc_pkg::MODE_MIN_TRIM);
    assign ax = wshc_pkg::nz16(is_min ? cfg.asp_min[15:0]  : cfg.asp_max[15:0]);
    assign ay = wshc_pkg::nz16(is_min ? cfg.asp_min[31:16] : cfg.asp_max[31:16]);
    assign xi = wshc_pkg::nz16(cfg.size_step[15:0]);
    assign yi = wshc_pkg::nz16(cfg.size_step[31:16]);

    // Cross products x*h and y*w.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_v_reg <= 1'b0;
        else
            p_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        p_item_reg <= in_item;
        ph_reg     <= ax * in_item.h;
        pw_reg     <= ay * in_item.w;
    end

    // The minimum ratio is violated when x*h > y*w, the maximum when x*h < y*w.
    always_comb
    begin
        p_item      = p_item_reg;
        p_item.cond = is_min ? (ph_reg > pw_reg) : (ph_reg < pw_reg);
    end

    // Width that matches the ratio, and height that matches the ratio.
    wshc_div u_div1_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_v_reg),
        .num       (ph_reg),
        .den       (ay),
        .in_item   (p_item),
        .out_valid (d1_v),
        .quo       (d1_qx),
        .out_item  (d1_item)
    );

    wshc_div u_div1_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_v_reg),
        .num       (pw_reg),
        .den       (ax),
        .in_item   (p_item),
        .out_valid (),
        .quo       (d1_qy),
        .out_item  ()
    );

    // Distance to the matching size; its sign is fixed by the step whenever it is used.
    always_comb
    begin
        w32 = {16'd0, d1_item.w};
        h32 = {16'd0, d1_item.h};
        tx  = (d1_qx >= w32) ? (d1_qx - w32) : (w32 - d1_qx);
        ty  = (d1_qy >= h32) ? (d1_qy - h32) : (h32 - d1_qy);
    end

    // Snap the distances down to whole increments.
    wshc_div u_div2_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_v),
        .num       (tx),
        .den       (xi),
        .in_item   (d1_item),
        .out_valid (d2_v),
        .quo       (d2_qx),
        .out_item  (d2_item)
    );

    wshc_div u_div2_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_v),
        .num       (ty),
        .den       (yi),
        .in_item   (d1_item),
        .out_valid (),
        .quo       (d2_qy),
        .out_item  ()
    );

    assign dx_full = d2_qx * xi;
    assign dy_full = d2_qy * yi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_v_reg <= 1'b0;
        else
            m_v_reg <= d2_v;
    end

    always_ff @(posedge clk)
    begin
        m_item_reg <= d2_item;
        dx_reg     <= dx_full[31:0];
        dy_reg     <= dy_full[31:0];
    end

    // If enabled and the test holds, apply a correction that keeps within size limits.
    always_comb
    begin
        w33       = {17'd0, m_item_reg.w};
        h33       = {17'd0, m_item_reg.h};
        grow_w_ok = (w33 + {1'b0, dx_reg}) <= {17'd0, cfg.max_size[15:0]};
        grow_h_ok = (h33 + {1'b0, dy_reg}) <= {17'd0, cfg.max_size[31:16]};
        trim_w_ok = w33 >= ({1'b0, dx_reg} + {17'd0, cfg.min_size[15:0]});
        trim_h_ok = h33 >= ({1'b0, dy_reg} + {17'd0, cfg.min_size[31:16]});
        active    = cfg.aspect_enable && m_item_reg.cond;
        res_next  = m_item_reg;
        unique case (mode)
            wshc_pkg::MODE_MIN_FIT:
            begin
                if (active && m_item_reg.xz && grow_w_ok)
                    res_next.w = m_item_reg.w + dx_reg[15:0];
            end
            wshc_pkg::MODE_MIN_TRIM:
            begin
                if (active)
                begin
                    if (trim_h_ok)
                        res_next.h = m_item_reg.h - dy_reg[15:0];
                    else if (grow_w_ok)
                        res_next.w = m_item_reg.w + dx_reg[15:0];
                end
            end
            wshc_pkg::MODE_MAX_FIT:
            begin
                if (active && m_item_reg.yz && grow_h_ok)
                    res_next.h = m_item_reg.h + dy_reg[15:0];
            end
            wshc_pkg::MODE_MAX_TRIM:
            begin
                if (active)
                begin
                    if (trim_w_ok)
                        res_next.w = m_item_reg.w - dx_reg[15:0];
                    else if (grow_h_ok)
                        res_next.h = m_item_reg.h + dy_reg[15:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= m_v_reg;
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= res_next;
    end

    assign out_valid = out_v_reg;
    assign out_item  = out_item_reg;

endmodule

[design/window_size_hint_constrain.sv]
// Top level of the window size hint constraint pipeline.
// Depends on wshc_pkg, wshc_div and wshc_step.
// The pipeline is 5 register stages, one snapping divider of 8 stages and four
// aspect steps of 19. It takes one transaction per cycle, so busy stays low; results
// cannot be stalled.
// Reset (rst_n low) clears all valid bits and loads the register reset values.

module window_size_hint_constrain (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [15:0]               req_width,
    input  logic signed [15:0]               req_height,
    input  logic signed [1:0]                x_dir,
    input  logic signed [1:0]                y_dir,
    input  logic                             shaded,
    input  logic                             cfg_we,
    input  logic [wshc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [31:0]                      cfg_wdata,
    output logic                             done,
    output logic signed [15:0]               out_width,
    output logic signed [15:0]               out_height
);

    wshc_pkg::cfg_t   cfg_reg;

    logic             s0_v_reg;
    logic [15:0]      s0_rw_reg;
    logic [15:0]      s0_rh_reg;
    logic [1:0]       s0_xd_reg;
    logic [1:0]       s0_yd_reg;
    logic             s0_sh_reg;

    logic [16:0]      side;
    logic [15:0]      title;
    logic signed [18:0] w0;
    logic signed [18:0] h0;
    logic signed [18:0] wa;
    logic signed [18:0] ha;
    logic signed [18:0] wb;
    logic signed [18:0] hb;
    wshc_pkg::item_t  s1_item_next;

    logic             s1_v_reg;
    wshc_pkg::item_t  s1_item_reg;

    logic [15:0]      bw;
    logic [15:0]      bh;
    logic [15:0]      xi;
    logic [15:0]      yi;
    logic [15:0]      mag_x;
    logic [15:0]      mag_y;
    wshc_pkg::item_t  snap_item;

    logic             fd_v;
    logic [31:0]      fd_qx;
    logic [31:0]      fd_qy;
    wshc_pkg::item_t  fd_item;
    logic [31:0]      px_full;
    logic [31:0]      py_full;

    logic             s2_v_reg;
    wshc_pkg::item_t  s2_item_reg;
    logic [15:0]      px_reg;
    logic [15:0]      py_reg;
    wshc_pkg::item_t  s3_item_next;

    logic             s3_v_reg;
    wshc_pkg::item_t  s3_item_reg;

    logic             step_v    [wshc_pkg::NUM_STEPS+1];
    wshc_pkg::item_t  step_item [wshc_pkg::NUM_STEPS+1];

    wshc_pkg::item_t  fin_item;
    logic [17:0]      sum_w;
    logic [17:0]      sum_h;
    logic             done_reg;
    logic [15:0]      out_width_reg;
    logic [15:0]      out_height_reg;

    // Every cycle can take a new transaction.
    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_size      <= wshc_pkg::MIN_SIZE_RST;
            cfg_reg.max_size      <= wshc_pkg::MAX_SIZE_RST;
            cfg_reg.base_size     <= wshc_pkg::BASE_SIZE_RST;
            cfg_reg.size_step     <= wshc_pkg::SIZE_STEP_RST;
            cfg_reg.asp_min       <= wshc_pkg::ASP_MIN_RST;
            cfg_reg.asp_max       <= wshc_pkg::ASP_MAX_RST;
            cfg_reg.frame_extra   <= wshc_pkg::FRAME_EXTRA_RST;
            cfg_reg.aspect_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                wshc_pkg::REG_MIN_SIZE:      cfg_reg.min_size      <= cfg_wdata;
                wshc_pkg::REG_MAX_SIZE:      cfg_reg.max_size      <= cfg_wdata;
                wshc_pkg::REG_BASE_SIZE:     cfg_reg.base_size     <= cfg_wdata;
                wshc_pkg::REG_SIZE_STEP:     cfg_reg.size_step     <= cfg_wdata;
                wshc_pkg::REG_ASP_MIN:       cfg_reg.asp_min       <= cfg_wdata;
                wshc_pkg::REG_ASP_MAX:       cfg_reg.asp_max       <= cfg_wdata;
                wshc_pkg::REG_FRAME_EXTRA:   cfg_reg.frame_extra   <= cfg_wdata;
                wshc_pkg::REG_ASPECT_ENABLE: cfg_reg.aspect_enable <= cfg_wdata[0];
            endcase
        end
    end

    // Input capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else
            s0_v_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s0_rw_reg <= req_width;
        s0_rh_reg <= req_height;
        s0_xd_reg <= x_dir;
        s0_yd_reg <= y_dir;
        s0_sh_reg <= shaded;
    end

    // Remove the frame allowance and clamp to the minimum, then the maximum.
    assign side  = {cfg_reg.frame_extra[15:0], 1'b0};
    assign title = cfg_reg.frame_extra[31:16];

    always_comb
    begin
        w0 = {{3{s0_rw_reg[15]}}, s0_rw_reg} - {2'b00, side};
        h0 = {{3{s0_rh_reg[15]}}, s0_rh_reg} - {3'b000, title} - {2'b00, side};
        wa = (w0 < $signed({3'b000, cfg_reg.min_size[15:0]}))
           ? $signed({3'b000, cfg_reg.min_size[15:0]}) : w0;
        ha = (h0 < $signed({3'b000, cfg_reg.min_size[31:16]}))
           ? $signed({3'b000, cfg_reg.min_size[31:16]}) : h0;
        wb = (wa > $signed({3'b000, cfg_reg.max_size[15:0]}))
           ? $signed({3'b000, cfg_reg.max_size[15:0]}) : wa;
        hb = (ha > $signed({3'b000, cfg_reg.max_size[31:16]}))
           ? $signed({3'b000, cfg_reg.max_size[31:16]}) : ha;
        s1_item_next      = '0;
        s1_item_next.w    = wb[15:0];
        s1_item_next.h    = hb[15:0];
        s1_item_next.rh   = s0_rh_reg;
        s1_item_next.xz   = (s0_xd_reg == 2'b00);
        s1_item_next.yz   = (s0_yd_reg == 2'b00);
        s1_item_next.sh   = s0_sh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else
            s1_v_reg <= s0_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
    end

    // Snap to base plus whole increments; truncation is toward zero, so divide magnitudes.
    assign bw = cfg_reg.base_size[15:0];
    assign bh = cfg_reg.base_size[31:16];
    assign xi = wshc_pkg::nz16(cfg_reg.size_step[15:0]);
    assign yi = wshc_pkg::nz16(cfg_reg.size_step[31:16]);

    always_comb
    begin
        snap_item    = s1_item_reg;
        snap_item.nx = s1_item_reg.w < bw;
        snap_item.ny = s1_item_reg.h < bh;
        mag_x = snap_item.nx ? (bw - s1_item_reg.w) : (s1_item_reg.w - bw);
        mag_y = snap_item.ny ? (bh - s1_item_reg.h) : (s1_item_reg.h - bh);
    end

    wshc_div u_snap_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_v_reg),
        .num       ({16'd0, mag_x}),
        .den       (xi),
        .in_item   (snap_item),
        .out_valid (fd_v),
        .quo       (fd_qx),
        .out_item  (fd_item)
    );

    wshc_div u_snap_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_v_reg),
        .num       ({16'd0, mag_y}),
        .den       (yi),
        .in_item   (snap_item),
        .out_valid (),
        .quo       (fd_qy),
        .out_item  ()
    );

    // The snapped magnitude never exceeds the original one, so 16 bits hold it.
    assign px_full = fd_qx[15:0] * xi;
    assign py_full = fd_qy[15:0] * yi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else
            s2_v_reg <= fd_v;
    end

    always_ff @(posedge clk)
    begin
        s2_item_reg <= fd_item;
        px_reg      <= px_full[15:0];
        py_reg      <= py_full[15:0];
    end

    always_comb
    begin
        s3_item_next   = s2_item_reg;
        s3_item_next.w = s2_item_reg.nx ? (bw - px_reg) : (bw + px_reg);
        s3_item_next.h = s2_item_reg.ny ? (bh - py_reg) : (bh + py_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_item_reg <= s3_item_next;
    end

    // Aspect corrections: minimum fit, minimum trim, maximum fit, maximum trim.
    assign step_v[0]    = s3_v_reg;
    assign step_item[0] = s3_item_reg;

    for (genvar g = 0; g < wshc_pkg::NUM_STEPS; g++)
    begin : g_step
        wshc_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .mode      (wshc_pkg::STEP_ORDER[g]),
            .cfg       (cfg_reg),
            .in_valid  (step_v[g]),
            .in_item   (step_item[g]),
            .out_valid (step_v[g+1]),
            .out_item  (step_item[g+1])
        );
    end

    // Add the frame allowance back and saturate; a shaded window keeps its requested height.
    assign fin_item = step_item[wshc_pkg::NUM_STEPS];
    assign sum_w = {2'b00, fin_item.w} + {1'b0, side};
    assign sum_h = {2'b00, fin_item.h} + {2'b00, title} + {1'b0, side};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= step_v[wshc_pkg::NUM_STEPS];
    end

    always_ff @(posedge clk)
    begin
        out_width_reg  <= wshc_pkg::sat_out(sum_w);
        out_height_reg <= fin_item.sh ? fin_item.rh : wshc_pkg::sat_out(sum_h);
    end

    assign done       = done_reg;
    assign out_width  = out_width_reg;
    assign out_height = out_height_reg;

    // Every result comes from an earlier accepted transaction.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, wshc_pkg::RESULT_LAT))
        else $error("result without a matching accepted transaction");

    // Every accepted transaction yields a result.
    a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(wshc_pkg::RESULT_LAT) done)
        else $error("accepted transaction produced no result");

    // Client size and frame allowance are never negative, so the width never is.
    a_width_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !out_width[15])
        else $error("constrained width is negative");

endmodule

[sim/window_size_hint_constrain_checker.sv]
// Checker for the window size hint constraint block: predicts each result and compares.
// Depends on wshc_pkg for register indexes and reset values.

module window_size_hint_constrain_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] req_width,
    input  logic signed [15:0] req_height,
    input  logic signed [1:0]  x_dir,
    input  logic signed [1:0]  y_dir,
    input  logic               shaded,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic               done,
    input  logic signed [15:0] out_width,
    input  logic signed [15:0] out_height,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] w;
        logic [15:0] h;
    } size_t;

    logic [31:0] min_r, max_r, base_r, step_r, mnasp_r, mxasp_r, frame_r;
    logic        asp_en;
    size_t       size_q[$];

    function automatic longint nonzero(input longint v);
        return (v == 0) ? 1 : v;
    endfunction

    // Truncating snap to a whole number of increments.
    function automatic longint snap_to(input longint a, input longint s);
        return (a / s) * s;
    endfunction

    function automatic logic [15:0] clamp_coord(input longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic size_t constrain_size(input logic signed [15:0] rw,
                                             input logic signed [15:0] rh,
                                             input logic signed [1:0] xd,
                                             input logic signed [1:0] yd,
                                             input logic sh);
        longint side, title, minw, minh, maxw, maxh, bw, bh, xi, yi;
        longint mnx, mny, mxx, mxy, w, h, d;
        size_t  r;
        side  = 2 * longint'(frame_r[15:0]);
        title = frame_r[31:16];
        minw = min_r[15:0];
        minh = min_r[31:16];
        maxw = max_r[15:0];
        maxh = max_r[31:16];
        bw = base_r[15:0];
        bh = base_r[31:16];
        xi = nonzero(step_r[15:0]);
        yi = nonzero(step_r[31:16]);
        mnx = nonzero(mnasp_r[15:0]);
        mny = nonzero(mnasp_r[31:16]);
        mxx = nonzero(mxasp_r[15:0]);
        mxy = nonzero(mxasp_r[31:16]);
        w = longint'(rw) - side;
        h = longint'(rh) - title - side;
        if (w < minw) w = minw;
        if (h < minh) h = minh;
        if (w > maxw) w = maxw;
        if (h > maxh) h = maxh;
        w = snap_to(w - bw, xi) + bw;
        h = snap_to(h - bh, yi) + bh;
        // Aspect corrections, minimum ratio first, then maximum.
        if (asp_en) begin
            if (mnx * h > mny * w && xd == 0) begin
                d = snap_to(mnx * h / mny - w, xi);
                if (w + d <= maxw) w += d;
            end
            if (mnx * h > mny * w) begin
                d = snap_to(h - w * mny / mnx, yi);
                if (h - d >= minh)
                    h -= d;
                else begin
                    d = snap_to(mnx * h / mny - w, xi);
                    if (w + d <= maxw) w += d;
                end
            end
            if (mxx * h < mxy * w && yd == 0) begin
                d = snap_to(w * mxy / mxx - h, yi);
                if (h + d <= maxh) h += d;
            end
            if (mxx * h < mxy * w) begin
                d = snap_to(w - mxx * h / mxy, xi);
                if (w - d >= minw)
                    w -= d;
                else begin
                    d = snap_to(w * mxy / mxx - h, yi);
                    if (h + d <= maxh) h += d;
                end
            end
        end
        r.w = clamp_coord(w + side);
        r.h = sh ? rh : clamp_coord(h + title + side);
        return r;
    endfunction

    assign pending = size_q.size();

    // Track registers, queue predictions and compare results.
    always @(posedge clk or negedge rst_n)
    begin
        size_t exp_sz;
        if (!rst_n) begin
            min_r = wshc_pkg::MIN_SIZE_RST;
            max_r = wshc_pkg::MAX_SIZE_RST;
            base_r = wshc_pkg::BASE_SIZE_RST;
            step_r = wshc_pkg::SIZE_STEP_RST;
            mnasp_r = wshc_pkg::ASP_MIN_RST;
            mxasp_r = wshc_pkg::ASP_MAX_RST;
            frame_r = wshc_pkg::FRAME_EXTRA_RST;
            asp_en = 1'b0;
            size_q.delete();
            fail_count = 0;
        end else begin
            if (done) begin
                if (size_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result %h/%h with nothing expected",
                             $time, out_width, out_height);
                end else begin
                    exp_sz = size_q.pop_front();
                    if (out_width !== exp_sz.w) begin
                        fail_count++;
                        $display("%0t: out_width expected %h actual %h",
                                 $time, exp_sz.w, out_width);
                    end
                    if (out_height !== exp_sz.h) begin
                        fail_count++;
                        $display("%0t: out_height expected %h actual %h",
                                 $time, exp_sz.h, out_height);
                    end
                end
            end
            if (start && !busy)
                size_q.push_back(constrain_size(req_width, req_height, x_dir, y_dir, shaded));
            if (cfg_we) begin
                case (cfg_addr)
                    wshc_pkg::REG_MIN_SIZE:      min_r = cfg_wdata;
                    wshc_pkg::REG_MAX_SIZE:      max_r = cfg_wdata;
                    wshc_pkg::REG_BASE_SIZE:     base_r = cfg_wdata;
                    wshc_pkg::REG_SIZE_STEP:     step_r = cfg_wdata;
                    wshc_pkg::REG_ASP_MIN:       mnasp_r = cfg_wdata;
                    wshc_pkg::REG_ASP_MAX:       mxasp_r = cfg_wdata;
                    wshc_pkg::REG_FRAME_EXTRA:   frame_r = cfg_wdata;
                    wshc_pkg::REG_ASPECT_ENABLE: asp_en = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

[sim/window_size_hint_constrain_tb.sv]
// Testbench top: clock, reset, register setup and request stimulus for the block.
// Depends on wshc_pkg, window_size_hint_constrain and window_size_hint_constrain_checker.

module window_size_hint_constrain_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] req_width;
    logic signed [15:0] req_height;
    logic signed [1:0]  x_dir;
    logic signed [1:0]  y_dir;
    logic               shaded;
    logic               cfg_we;
    logic [2:0]         cfg_addr;
    logic [31:0]        cfg_wdata;
    logic               done;
    logic signed [15:0] out_width;
    logic signed [15:0] out_height;
    int                 fail_count;
    int                 pending;
    bit                 no_gaps;

    window_size_hint_constrain uut (.*);
    window_size_hint_constrain_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Write one register at the next edge.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every outstanding request has returned, then let the pipe drain.
    task automatic drain_pipe();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (wshc_pkg::RESULT_LAT + 4) @(posedge clk);
    endtask

    // Offer one request, holding it until accepted, with optional idle cycles first.
    task automatic send_request(input logic [15:0] rw, input logic [15:0] rh,
                                input logic [1:0] xd, input logic [1:0] yd,
                                input logic sh);
        if (!no_gaps && $urandom_range(99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        start <= 1'b1;
        req_width <= rw;
        req_height <= rh;
        x_dir <= xd;
        y_dir <= yd;
        shaded <= sh;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic [15:0] rw, rh;
        case ($urandom_range(3))
            0: begin
                rw = 16'($urandom);
                rh = 16'($urandom);
            end
            default: begin
                rw = 16'($urandom_range(600));
                rh = 16'($urandom_range(600));
            end
        endcase
        send_request(rw, rh, 2'($urandom), 2'($urandom), $urandom_range(7) == 0);
    endtask

    // Small field-pair register value, with each field occasionally drawn from the full 16-bit range.
    function automatic logic [31:0] pair_value(input int lim);
        logic [15:0] a, b;
        a = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(lim));
        b = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(lim));
        return {b, a};
    endfunction

    initial
    begin
        #200000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_width = '0;
        req_height = '0;
        x_dir = '0;
        y_dir = '0;
        shaded = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = wshc_pkg::REG_MIN_SIZE;
        cfg_wdata = '0;
        no_gaps = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with reset registers: field extremes and direction codes.
        send_request(16'h7FFF, 16'h8000, 2'b00, 2'b01, 1'b0);
        send_request(16'h8000, 16'h7FFF, 2'b11, 2'b10, 1'b1);
        send_request(16'h0000, 16'hFFFF, 2'b10, 2'b00, 1'b0);
        drain_pipe();

        // Aspect on, minimum above maximum, zero increments and aspect terms.
        write_reg(wshc_pkg::REG_MIN_SIZE, {16'd300, 16'd300});
        write_reg(wshc_pkg::REG_MAX_SIZE, {16'd200, 16'd100});
        write_reg(wshc_pkg::REG_BASE_SIZE, {16'd3, 16'd5});
        write_reg(wshc_pkg::REG_SIZE_STEP, 32'h0000_0000);
        write_reg(wshc_pkg::REG_ASP_MIN, 32'h0000_0000);
        write_reg(wshc_pkg::REG_ASP_MAX, {16'd1, 16'd4});
        write_reg(wshc_pkg::REG_FRAME_EXTRA, {16'd20, 16'd4});
        write_reg(wshc_pkg::REG_ASPECT_ENABLE, 32'd1);
        for (int i = 0; i < 4; i++)
            send_request(16'(i * 150), 16'(500 - i * 120), 2'(i), 2'(3 - i), i[0]);
        drain_pipe();

        // Extreme registers: saturation of the output.
        write_reg(wshc_pkg::REG_MIN_SIZE, 32'hFFFF_FFFF);
        write_reg(wshc_pkg::REG_MAX_SIZE, 32'hFFFF_FFFF);
        write_reg(wshc_pkg::REG_FRAME_EXTRA, 32'hFFFF_FFFF);
        write_reg(wshc_pkg::REG_SIZE_STEP, 32'hFFFF_FFFF);
        write_reg(wshc_pkg::REG_BASE_SIZE, 32'hFFFF_FFFF);
        write_reg(wshc_pkg::REG_ASP_MIN, 32'hFFFF_0001);
        write_reg(wshc_pkg::REG_ASP_MAX, 32'h0001_FFFF);
        send_request(16'h7FFF, 16'h7FFF, 2'b00, 2'b00, 1'b0);
        send_request(16'h8000, 16'h8000, 2'b01, 2'b11, 1'b0);
        drain_pipe();

        // Random phases with fresh register settings.
        for (int ph = 0; ph < 11; ph++) begin
            write_reg(wshc_pkg::REG_MIN_SIZE, pair_value(150));
            write_reg(wshc_pkg::REG_MAX_SIZE, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF
                                              : pair_value(700));
            write_reg(wshc_pkg::REG_BASE_SIZE, pair_value(30));
            write_reg(wshc_pkg::REG_SIZE_STEP, pair_value(16));
            write_reg(wshc_pkg::REG_ASP_MIN, pair_value(12));
            write_reg(wshc_pkg::REG_ASP_MAX, pair_value(12));
            write_reg(wshc_pkg::REG_FRAME_EXTRA, pair_value(25));
            write_reg(wshc_pkg::REG_ASPECT_ENABLE, 32'($urandom_range(3) != 0));
            no_gaps = (ph == 4);
            for (int n = 0; n < 48; n++)
                send_random();
            drain_pipe();
        end
        no_gaps = 1'b0;

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
